// ----- src/can_cyclic_event_tx_scheduler_macros.svh -----
// assertion helpers used by the scheduler back end
// each one expects i_clk and i_rst_n in scope
`ifndef CAN_CYCLIC_EVENT_TX_SCHEDULER_MACROS_SVH
`define CAN_CYCLIC_EVENT_TX_SCHEDULER_MACROS_SVH

// same-cycle implication
`define CCES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cces_pkg.sv -----
`timescale 1ns / 1ps

package cces_pkg;

    // decoded operations, same encoding as the command field
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_TRIG    = 3'd1;
    localparam logic [2:0] OP_LOAD    = 3'd2;
    localparam logic [2:0] OP_PERIOD  = 3'd3;
    localparam logic [2:0] OP_BIND    = 3'd4;
    localparam logic [2:0] OP_RESTART = 3'd5;
    localparam logic [2:0] OP_CLEAR   = 3'd6;
    localparam logic [2:0] OP_NONE    = 3'd7;

    // result kinds and status codes
    localparam logic RK_FRAME  = 1'b0;
    localparam logic RK_STATUS = 1'b1;
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_MISS   = 1'b1;

    localparam logic [3:0] FULL_LEN = 4'd8;

    // classified command beat, queued between front and back
    typedef struct packed {
        logic [2:0]  op;
        logic [4:0]  slot;
        logic        bind_ok;
        logic [10:0] fid;
        logic [3:0]  len;
        logic [63:0] data;
        logic [15:0] per;
        logic [31:0] now;
    } t_item;

    // result beat
    typedef struct packed {
        logic        kind;
        logic        status;
        logic [10:0] id;
        logic [3:0]  length;
        logic [63:0] data;
        logic        last;
    } t_result;

    function automatic logic [3:0] clamp_len(input logic [3:0] n);
        return (n > FULL_LEN) ? FULL_LEN : n;
    endfunction

    // byte mask covering the first len bytes
    function automatic logic [63:0] len_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            m[8*b +: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ----- src/can_cyclic_event_tx_scheduler.sv -----
`timescale 1ns / 1ps
// Flow (n = slots in use): bind and clear go straight to the status beat, restart writes
//   the last-send time of the n slots, trigger, load and period search the first n slots
//   for the frame id, tick sends every due slot and marks its last frame; the slot walk reads
//   the slot table one entry per cycle, and a full result queue stalls the tick walk.
//   The next command is taken only once the sequencer is back in idle.
// Reset: synchronous, active low; clears queues, slot_count, pending marks and last-send
//   valid bits (last send reads zero); slot id, length, payload, period undefined until written.
module can_cyclic_event_tx_scheduler import cces_pkg::*; #(
    parameter int MAX_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command side
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_command,
    input  logic [4:0]  i_slot_index,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_byte_count,
    input  logic [63:0] i_payload,
    input  logic [15:0] i_period_ms,
    input  logic [31:0] i_now_ms,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic        o_status,
    output logic [10:0] o_out_id,
    output logic [3:0]  o_out_length,
    output logic [63:0] o_out_data,
    output logic        o_last
);

    localparam int CW = $clog2(MAX_SLOTS + 1);

    logic [5:0]    r_slot_count;
    logic [CW-1:0] n_use;
    t_item         item;
    logic          item_empty, item_pop;
    t_result       res, res_q;
    logic          res_push, res_full;

    // register file
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {26'd0, r_slot_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_slot_count <= pwdata[5:0];
        end
    end

    // slots in use, limited to the table size
    assign n_use = ({26'd0, r_slot_count} > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS)
                                                           : CW'(r_slot_count);

    cces_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_command    (i_command),
        .i_slot_index (i_slot_index),
        .i_frame_id   (i_frame_id),
        .i_byte_count (i_byte_count),
        .i_payload    (i_payload),
        .i_period_ms  (i_period_ms),
        .i_now_ms     (i_now_ms),
        .i_pop        (item_pop),
        .o_item       (item),
        .o_empty      (item_empty)
    );

    cces_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_n          (n_use),
        .i_item       (item),
        .i_item_empty (item_empty),
        .o_item_pop   (item_pop),
        .o_res        (res),
        .o_res_push   (res_push),
        .i_out_full   (res_full)
    );

    // result queue
    cces_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign o_result_kind = res_q.kind;
    assign o_status      = res_q.status;
    assign o_out_id      = res_q.id;
    assign o_out_length  = res_q.length;
    assign o_out_data    = res_q.data;
    assign o_last        = res_q.last;

endmodule

// ----- src/cces_fifo.sv -----
`timescale 1ns / 1ps

module cces_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [NW-1:0]    r_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/cces_front.sv -----
`timescale 1ns / 1ps

module cces_front import cces_pkg::*; #(
    parameter int MAX_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_command,
    input  logic [4:0]  i_slot_index,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_byte_count,
    input  logic [63:0] i_payload,
    input  logic [15:0] i_period_ms,
    input  logic [31:0] i_now_ms,
    input  logic        i_pop,
    output t_item       o_item,
    output logic        o_empty
);

    t_item item;
    logic  keep;

    // decode and classify the incoming beat
    always_comb begin
        item.slot    = i_slot_index;
        item.bind_ok = ({27'b0, i_slot_index} < 32'(MAX_SLOTS));
        item.fid     = i_frame_id;
        item.len     = clamp_len(i_byte_count);
        item.data    = i_payload;
        item.per     = i_period_ms;
        item.now     = i_now_ms;
        unique case (i_command)
            OP_TICK:    item.op = OP_TICK;
            OP_TRIG:    item.op = OP_TRIG;
            OP_LOAD:    item.op = OP_LOAD;
            OP_PERIOD:  item.op = OP_PERIOD;
            OP_BIND:    item.op = OP_BIND;
            OP_RESTART: item.op = OP_RESTART;
            OP_CLEAR:   item.op = OP_CLEAR;
            default:    item.op = OP_NONE;
        endcase
    end

    // unknown commands are taken and dropped here
    assign keep = i_push && (item.op != OP_NONE);

    cces_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (keep),
        .i_data  (item),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

endmodule

// ----- src/cces_back.sv -----
`timescale 1ns / 1ps
`include "can_cyclic_event_tx_scheduler_macros.svh"

module cces_back import cces_pkg::*; #(
    parameter  int MAX_SLOTS = 32,
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int CW = $clog2(MAX_SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [CW-1:0] i_n,
    input  t_item         i_item,
    input  logic          i_item_empty,
    output logic          o_item_pop,
    output t_result       o_res,
    output logic          o_res_push,
    input  logic          i_out_full
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_FIND  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_STAT  = 3'd4;

    // slot tables
    logic [10:0] m_id   [MAX_SLOTS];
    logic [3:0]  m_len  [MAX_SLOTS];
    logic [63:0] m_pay  [MAX_SLOTS];
    logic [15:0] m_per  [MAX_SLOTS];
    logic [31:0] m_last [MAX_SLOTS];

    logic [MAX_SLOTS-1:0] r_pend, r_lv;

    logic [10:0] r_q_id;
    logic [3:0]  r_q_len;
    logic [63:0] r_q_pay;
    logic [15:0] r_q_per;
    logic [31:0] r_q_last;
    logic [SW-1:0] r_rd_idx;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_rd_valid, n_rd_valid;
    logic          r_hold_v, n_hold_v;
    t_result       r_hold, n_hold;
    logic          r_err, n_err;
    t_item         r_cmd, n_cmd;

    logic          rd_en;
    logic [SW-1:0] wa;
    logic          we_id, we_len, we_pay, we_per, we_last;
    logic [10:0]   wd_id;
    logic [3:0]    wd_len;
    logic [63:0]   wd_pay;
    logic [15:0]   wd_per;
    logic          pend_set, pend_clr, lv_set, clr_all;

    logic [31:0] q_last, elapsed;
    logic        due, more, stall, match;
    logic [3:0]  frm_len;
    logic [63:0] ld_mask;
    t_result     frame, stat;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_rd_valid = r_rd_valid;
        n_hold_v   = r_hold_v;
        n_hold     = r_hold;
        n_err      = r_err;
        n_cmd      = r_cmd;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        rd_en      = 1'b0;
        wa         = r_rd_idx;
        we_id      = 1'b0;
        we_len     = 1'b0;
        we_pay     = 1'b0;
        we_per     = 1'b0;
        we_last    = 1'b0;
        wd_id      = i_item.fid;
        wd_len     = r_cmd.len;
        wd_pay     = '0;
        wd_per     = r_cmd.per;
        pend_set   = 1'b0;
        pend_clr   = 1'b0;
        lv_set     = 1'b0;
        clr_all    = 1'b0;
        stall      = 1'b0;

        // slot evaluation from the read registers
        q_last   = r_lv[r_rd_idx] ? r_q_last : 32'd0;
        elapsed  = r_cmd.now - q_last;
        due      = r_pend[r_rd_idx] ||
                   ((r_q_per != 16'd0) && (elapsed >= {16'd0, r_q_per}));
        match    = (r_q_id == r_cmd.fid);
        more     = (r_idx < i_n);
        frm_len  = clamp_len(r_q_len);
        ld_mask  = len_mask(r_cmd.len);

        frame.kind   = RK_FRAME;
        frame.status = ST_OK;
        frame.id     = r_q_id;
        frame.length = frm_len;
        frame.data   = r_q_pay & len_mask(frm_len);
        frame.last   = 1'b0;

        stat.kind    = RK_STATUS;
        stat.status  = r_err;
        stat.id      = '0;
        stat.length  = '0;
        stat.data    = '0;
        stat.last    = 1'b1;
        o_res        = stat;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_item_empty) begin
                    o_item_pop = 1'b1;
                    n_cmd      = i_item;
                    n_idx      = '0;
                    n_rd_valid = 1'b0;
                    n_hold_v   = 1'b0;
                    n_err      = ST_OK;
                    case (i_item.op)
                        OP_TICK:    n_state = ST_WALK;
                        OP_TRIG,
                        OP_LOAD,
                        OP_PERIOD:  n_state = ST_FIND;
                        OP_RESTART: n_state = ST_SWEEP;
                        OP_CLEAR: begin
                            clr_all = 1'b1;
                            n_state = ST_STAT;
                        end
                        OP_BIND: begin
                            wa      = SW'(i_item.slot);
                            wd_len  = i_item.len;
                            wd_per  = i_item.per;
                            wd_pay  = '0;
                            we_id   = i_item.bind_ok;
                            we_len  = i_item.bind_ok;
                            we_pay  = i_item.bind_ok;
                            we_per  = i_item.bind_ok;
                            n_err   = i_item.bind_ok ? ST_OK : ST_MISS;
                            n_state = ST_STAT;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            ST_WALK: begin
                // retire the slot in the read registers, hold one frame back for last
                if (r_rd_valid && due) begin
                    stall = r_hold_v && i_out_full;
                    if (!stall) begin
                        o_res_push = r_hold_v;
                        o_res      = r_hold;
                        n_hold     = frame;
                        n_hold_v   = 1'b1;
                        we_last    = 1'b1;
                        lv_set     = 1'b1;
                        pend_clr   = 1'b1;
                    end
                end
                if (!stall) begin
                    rd_en      = more;
                    n_rd_valid = more;
                    if (more) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                // walk finished: flush the held frame as the last beat
                if (!r_rd_valid && !more) begin
                    if (!r_hold_v) begin
                        n_state = ST_IDLE;
                    end else if (!i_out_full) begin
                        o_res_push  = 1'b1;
                        o_res       = r_hold;
                        o_res.last  = 1'b1;
                        n_hold_v    = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end
            end

            ST_FIND: begin
                if (r_rd_valid && match) begin
                    n_rd_valid = 1'b0;
                    n_err      = ST_OK;
                    n_state    = ST_STAT;
                    case (r_cmd.op)
                        OP_TRIG:   pend_set = 1'b1;
                        OP_LOAD: begin
                            we_pay = 1'b1;
                            we_len = 1'b1;
                            wd_pay = (r_q_pay & ~ld_mask) | (r_cmd.data & ld_mask);
                        end
                        OP_PERIOD: we_per = 1'b1;
                        default:   n_err = r_err;
                    endcase
                end else begin
                    rd_en      = more;
                    n_rd_valid = more;
                    if (more) begin
                        n_idx = r_idx + 1'b1;
                    end
                    if (!r_rd_valid && !more) begin
                        n_err   = ST_MISS;
                        n_state = ST_STAT;
                    end
                end
            end

            ST_SWEEP: begin
                wa = r_idx[SW-1:0];
                if (more) begin
                    we_last = 1'b1;
                    lv_set  = 1'b1;
                    n_idx   = r_idx + 1'b1;
                end else begin
                    n_err   = ST_OK;
                    n_state = ST_STAT;
                end
            end

            ST_STAT: begin
                if (!i_out_full) begin
                    o_res_push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_rd_valid <= 1'b0;
            r_hold_v   <= 1'b0;
            r_err      <= ST_OK;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_rd_valid <= n_rd_valid;
            r_hold_v   <= n_hold_v;
            r_err      <= n_err;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_cmd  <= n_cmd;
    end

    // pending marks and last-send valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_lv   <= '0;
        end else begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                if (clr_all && (CW'(i) < i_n)) begin
                    r_pend[i] <= 1'b0;
                end
            end
            if (pend_set) begin
                r_pend[wa] <= 1'b1;
            end
            if (pend_clr) begin
                r_pend[wa] <= 1'b0;
            end
            if (lv_set) begin
                r_lv[wa] <= 1'b1;
            end
        end
    end

    // slot table memories, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (we_id) begin
            m_id[wa] <= wd_id;
        end
        if (we_len) begin
            m_len[wa] <= wd_len;
        end
        if (we_pay) begin
            m_pay[wa] <= wd_pay;
        end
        if (we_per) begin
            m_per[wa] <= wd_per;
        end
        if (we_last) begin
            m_last[wa] <= r_cmd.now;
        end
        if (rd_en) begin
            r_q_id   <= m_id[r_idx[SW-1:0]];
            r_q_len  <= m_len[r_idx[SW-1:0]];
            r_q_pay  <= m_pay[r_idx[SW-1:0]];
            r_q_per  <= m_per[r_idx[SW-1:0]];
            r_q_last <= m_last[r_idx[SW-1:0]];
            r_rd_idx <= r_idx[SW-1:0];
        end
    end

    `CCES_ASSERT_IMP(a_no_push_full, o_res_push, !i_out_full, "result beat pushed into full queue")
    `CCES_ASSERT_IMP(a_pop_idle, o_item_pop, r_state == ST_IDLE, "command taken while busy")
    `CCES_ASSERT_NEXT(a_stat_done, (r_state == ST_STAT) && !i_out_full, r_state == ST_IDLE, "status not retired")
    `CCES_ASSERT_IMP(a_rd_walk, r_rd_valid, (r_state == ST_WALK) || (r_state == ST_FIND), "stray slot read")
    `CCES_ASSERT_IMP(a_hold_tick, r_hold_v, r_state == ST_WALK, "held frame outside a tick")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb import cces_pkg::*; ();

    localparam int SLOT_LIMIT    = 32;
    localparam int QUIET_CYCLES  = 128;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SEGMENT_ITEMS = 42;
    localparam logic [2:0] ADDR_SLOT_COUNT = 3'd0;

    // one command beat as driven on the input side
    typedef struct packed {
        logic [2:0]  cmd;
        logic [4:0]  slot;
        logic [10:0] fid;
        logic [3:0]  cnt;
        logic [63:0] data;
        logic [15:0] per;
        logic [31:0] now;
    } t_sched_cmd;

    // slot table mirror and queue of frames and status beats still to come
    class sched_scoreboard;
        int unsigned slot_count;
        logic [10:0] id_tab   [SLOT_LIMIT];
        logic [3:0]  len_tab  [SLOT_LIMIT];
        logic [63:0] data_tab [SLOT_LIMIT];
        logic [15:0] per_tab  [SLOT_LIMIT];
        logic [31:0] sent_at  [SLOT_LIMIT];
        bit          pend     [SLOT_LIMIT];
        t_result     queued_results[$];
        int          fail_count;
        int          frames_checked;
        int          status_checked;

        function new();
            slot_count = 0;
            for (int i = 0; i < SLOT_LIMIT; i++) begin
                id_tab[i]   = '0;
                len_tab[i]  = '0;
                data_tab[i] = '0;
                per_tab[i]  = '0;
                sent_at[i]  = '0;
                pend[i]     = 1'b0;
            end
            fail_count     = 0;
            frames_checked = 0;
            status_checked = 0;
        endfunction

        function int active();
            return (slot_count < SLOT_LIMIT) ? int'(slot_count) : SLOT_LIMIT;
        endfunction

        function logic [3:0] clamp(logic [3:0] n);
            return (n > 4'd8) ? 4'd8 : n;
        endfunction

        function logic [63:0] byte_mask(logic [3:0] n);
            if (n >= 4'd8) return '1;
            return (64'd1 << (8 * n)) - 64'd1;
        endfunction

        // lowest slot in use with this id wins
        function int find_slot(logic [10:0] fid);
            for (int i = 0; i < active(); i++) begin
                if (id_tab[i] == fid) return i;
            end
            return -1;
        endfunction

        function int outstanding();
            return queued_results.size();
        endfunction

        // update the slot table and queue the beats this command causes
        function void apply_command(t_sched_cmd c);
            t_result     held;
            bit          have_held;
            bit          miss;
            int          s;
            logic [3:0]  l;
            logic [63:0] m;
            logic [31:0] age;
            have_held = 1'b0;
            miss      = 1'b0;
            held      = '0;
            l         = clamp(c.cnt);
            case (c.cmd)
                OP_TICK: begin
                    for (int i = 0; i < active(); i++) begin
                        age = c.now - sent_at[i];
                        if (pend[i] || (per_tab[i] != 16'd0 && age >= {16'd0, per_tab[i]})) begin
                            if (have_held) queued_results.push_back(held);
                            held        = '0;
                            held.kind   = RK_FRAME;
                            held.status = ST_OK;
                            held.id     = id_tab[i];
                            held.length = clamp(len_tab[i]);
                            held.data   = data_tab[i] & byte_mask(clamp(len_tab[i]));
                            have_held   = 1'b1;
                            sent_at[i]  = c.now;
                            pend[i]     = 1'b0;
                        end
                    end
                    if (have_held) begin
                        held.last = 1'b1;
                        queued_results.push_back(held);
                    end
                    return;
                end
                OP_TRIG: begin
                    s = find_slot(c.fid);
                    if (s < 0) miss = 1'b1;
                    else pend[s] = 1'b1;
                end
                OP_LOAD: begin
                    s = find_slot(c.fid);
                    if (s < 0) miss = 1'b1;
                    else begin
                        m = byte_mask(l);
                        data_tab[s] = (data_tab[s] & ~m) | (c.data & m);
                        len_tab[s]  = l;
                    end
                end
                OP_PERIOD: begin
                    s = find_slot(c.fid);
                    if (s < 0) miss = 1'b1;
                    else per_tab[s] = c.per;
                end
                OP_BIND: begin
                    if (int'(c.slot) >= SLOT_LIMIT) miss = 1'b1;
                    else begin
                        id_tab[c.slot]   = c.fid;
                        len_tab[c.slot]  = l;
                        data_tab[c.slot] = '0;
                        per_tab[c.slot]  = c.per;
                    end
                end
                OP_RESTART: begin
                    for (int i = 0; i < active(); i++) sent_at[i] = c.now;
                end
                OP_CLEAR: begin
                    for (int i = 0; i < active(); i++) pend[i] = 1'b0;
                end
                OP_NONE: return;
            endcase
            held        = '0;
            held.kind   = RK_STATUS;
            held.status = miss ? ST_MISS : ST_OK;
            held.last   = 1'b1;
            queued_results.push_back(held);
        endfunction

        function void field_check(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                fail_count++;
            end
        endfunction

        // compare one popped beat against the oldest queued one
        function void check_result(t_result got);
            t_result want;
            if (queued_results.size() == 0) begin
                $error("result beat with nothing queued: kind %0h id %0h", got.kind, got.id);
                fail_count++;
                return;
            end
            want = queued_results.pop_front();
            field_check("result_kind", 64'(want.kind), 64'(got.kind));
            field_check("status", 64'(want.status), 64'(got.status));
            field_check("out_id", 64'(want.id), 64'(got.id));
            field_check("out_length", 64'(want.length), 64'(got.length));
            field_check("out_data", want.data, got.data);
            field_check("last", 64'(want.last), 64'(got.last));
            if (want.kind == RK_FRAME) frames_checked++;
            else status_checked++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic [2:0]  cmd_in;
    logic [4:0]  slot_in;
    logic [10:0] fid_in;
    logic [3:0]  cnt_in;
    logic [63:0] data_in;
    logic [15:0] per_in;
    logic [31:0] now_in;
    logic        empty;
    logic        pop;
    logic        res_kind;
    logic        res_status;
    logic [10:0] res_id;
    logic [3:0]  res_length;
    logic [63:0] res_data;
    logic        res_last;

    sched_scoreboard sb = new();
    int          send_idle_pct = 33;
    int          pop_idle_pct  = 83;
    int          cycles        = 0;
    int          items_sent    = 0;
    int          settings_done = 0;
    logic [31:0] wall_ms       = '0;

    can_cyclic_event_tx_scheduler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .i_command     (cmd_in),
        .i_slot_index  (slot_in),
        .i_frame_id    (fid_in),
        .i_byte_count  (cnt_in),
        .i_payload     (data_in),
        .i_period_ms   (per_in),
        .i_now_ms      (now_in),
        .empty         (empty),
        .pop           (pop),
        .o_result_kind (res_kind),
        .o_status      (res_status),
        .o_out_id      (res_id),
        .o_out_length  (res_length),
        .o_out_data    (res_data),
        .o_last        (res_last)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random pop stalls, check every accepted beat
    initial begin
        t_result got;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop = ($urandom_range(0, 99) >= pop_idle_pct);
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.kind   = res_kind;
                got.status = res_status;
                got.id     = res_id;
                got.length = res_length;
                got.data   = res_data;
                got.last   = res_last;
                sb.check_result(got);
            end
        end
    end

    function automatic logic [10:0] pool_id();
        case ($urandom_range(0, 9))
            0:       return 11'h000;
            1:       return 11'h7FF;
            2:       return 11'h001;
            3:       return 11'h400;
            4:       return 11'h2AA;
            5:       return 11'h555;
            6:       return 11'h123;
            7:       return 11'h7F0;
            8:       return 11'h00F;
            default: return 11'h3C3;
        endcase
    endfunction

    function automatic logic [15:0] draw_period();
        case ($urandom_range(0, 9))
            0, 1:    return 16'd0;
            7:       return 16'hFFFF;
            8:       return 16'($urandom);
            9:       return 16'($urandom_range(31, 200));
            default: return 16'($urandom_range(1, 30));
        endcase
    endfunction

    // mostly small steps, sometimes long gaps or an arbitrary jump
    function automatic logic [31:0] advance_wall_clock();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 90) wall_ms = wall_ms + 32'($urandom_range(0, 20));
        else if (roll < 97) wall_ms = wall_ms + 32'($urandom_range(1000, 70000));
        else wall_ms = $urandom;
        return wall_ms;
    endfunction

    // well-formed commands on known ids, with some misses and noise
    function automatic t_sched_cmd draw_command();
        t_sched_cmd  c;
        int unsigned roll;
        c.slot = 5'($urandom_range(0, 31));
        c.fid  = ($urandom_range(0, 9) == 0) ? 11'($urandom) : pool_id();
        c.cnt  = 4'($urandom);
        c.data = {$urandom, $urandom};
        c.per  = draw_period();
        c.now  = $urandom;
        roll   = $urandom_range(0, 99);
        if (roll < 35) c.cmd = OP_TICK;
        else if (roll < 50) c.cmd = OP_TRIG;
        else if (roll < 62) c.cmd = OP_LOAD;
        else if (roll < 70) c.cmd = OP_PERIOD;
        else if (roll < 80) c.cmd = OP_BIND;
        else if (roll < 85) c.cmd = OP_RESTART;
        else if (roll < 90) c.cmd = OP_CLEAR;
        else if (roll < 93) c.cmd = OP_NONE;
        else begin
            c.cmd = 3'($urandom);
            c.fid = 11'($urandom);
        end
        if (c.cmd == OP_TICK || c.cmd == OP_RESTART) c.now = advance_wall_clock();
        return c;
    endfunction

    // push one command beat, with random idle cycles ahead of it
    task automatic send_command(t_sched_cmd c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push    = 1'b1;
        cmd_in  = c.cmd;
        slot_in = c.slot;
        fid_in  = c.fid;
        cnt_in  = c.cnt;
        data_in = c.data;
        per_in  = c.per;
        now_in  = c.now;
        do @(posedge i_clk); while (full);
        sb.apply_command(c);
        if (c.cmd != OP_NONE) items_sent++;
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic issue(logic [2:0] op, logic [4:0] slot, logic [10:0] fid, logic [3:0] cnt,
                         logic [63:0] data, logic [15:0] per, logic [31:0] now_v);
        t_sched_cmd c;
        c.cmd  = op;
        c.slot = slot;
        c.fid  = fid;
        c.cnt  = cnt;
        c.data = data;
        c.per  = per;
        c.now  = now_v;
        send_command(c);
    endtask

    // drain every queued beat, then let the slot walk settle
    task automatic wait_quiet();
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    // write slot_count, then read it back
    task automatic write_slot_count(logic [5:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_SLOT_COUNT;
        pwdata  = 32'(v);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.slot_count = v;
        settings_done++;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[5:0] !== v) begin
            $error("slot_count readback mismatch: expected %0h, actual %0h", v, prdata[5:0]);
            sb.fail_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    initial begin
        int counts [6];
        int sent;
        t_sched_cmd c;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        push    = 1'b0;
        cmd_in  = '0;
        slot_in = '0;
        fid_in  = '0;
        cnt_in  = '0;
        data_in = '0;
        per_in  = '0;
        now_in  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // no slots in use: lookups miss, tick is silent, unknown command ignored
        write_slot_count(6'd0);
        issue(OP_TRIG, 5'd0, 11'h7FF, 4'd0, '0, 16'd0, '0);
        issue(OP_LOAD, 5'd0, 11'h000, 4'd8, '1, 16'd0, '0);
        issue(OP_PERIOD, 5'd0, 11'h555, 4'd0, '0, 16'hFFFF, '0);
        issue(OP_TICK, 5'd0, 11'h000, 4'd0, '0, 16'd0, 32'd0);
        issue(OP_RESTART, 5'd0, 11'h000, 4'd0, '0, 16'd0, 32'hFFFF_FFFF);
        issue(OP_CLEAR, 5'd0, 11'h000, 4'd0, '0, 16'd0, '0);
        issue(OP_NONE, 5'd31, 11'h7FF, 4'hF, '1, 16'hFFFF, 32'hFFFF_FFFF);

        // bind every slot so any later slot count walks defined entries
        for (int k = 0; k < SLOT_LIMIT; k++)
            issue(OP_BIND, 5'(k), pool_id(), 4'($urandom), {$urandom, $urandom}, draw_period(),
                  $urandom);
        wait_quiet();

        // count above the table size is taken as the full table
        write_slot_count(6'd63);
        issue(OP_BIND, 5'd0, 11'h000, 4'hF, '1, 16'd0, '0);
        issue(OP_BIND, 5'd31, 11'h7FF, 4'd0, '0, 16'hFFFF, '0);
        issue(OP_BIND, 5'd7, 11'h000, 4'd8, '0, 16'd3, '0);
        issue(OP_LOAD, 5'd0, 11'h000, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, '0);
        issue(OP_LOAD, 5'd0, 11'h7FF, 4'd3, 64'hA5A5_A5A5_A5A5_A5A5, 16'd0, '0);
        issue(OP_TRIG, 5'd0, 11'h000, 4'd0, '0, 16'd0, '0);
        issue(OP_RESTART, 5'd0, 11'h000, 4'd0, '0, 16'd0, 32'hFFFF_FFF0);
        // pending slot goes out even with a zero period and no time elapsed
        issue(OP_TICK, 5'd0, 11'h000, 4'd0, '0, 16'd0, 32'hFFFF_FFF0);
        // elapsed time wraps through zero
        issue(OP_TICK, 5'd0, 11'h000, 4'd0, '0, 16'd0, 32'h0000_0005);
        issue(OP_TRIG, 5'd0, 11'h7FF, 4'd0, '0, 16'd0, '0);
        issue(OP_CLEAR, 5'd0, 11'h000, 4'd0, '0, 16'd0, '0);
        issue(OP_TICK, 5'd0, 11'h000, 4'd0, '0, 16'd0, 32'h0000_0006);
        issue(OP_PERIOD, 5'd0, 11'h000, 4'd0, '0, 16'd1, '0);
        issue(OP_TICK, 5'd0, 11'h000, 4'd0, '0, 16'd0, 32'h0000_0007);
        issue(OP_TICK, 5'd0, 11'h000, 4'd0, '0, 16'd0, 32'h0001_0010);
        issue(OP_NONE, 5'd0, 11'h000, 4'd0, '0, 16'd0, '0);

        // random segments over several slot counts and idle profiles
        wall_ms = 32'h0002_0000;
        counts  = '{1, 32, $urandom_range(2, 31), 63, $urandom_range(0, 63), 17};
        for (int seg = 0; seg < 6; seg++) begin
            wait_quiet();
            if (seg == 2) begin
                send_idle_pct = 83;
                pop_idle_pct  = 33;
            end else if (seg == 4) begin
                send_idle_pct = 0;
                pop_idle_pct  = 0;
            end
            write_slot_count(6'(counts[seg]));
            sent = 0;
            while (sent < SEGMENT_ITEMS) begin
                c = draw_command();
                send_command(c);
                if (c.cmd != OP_NONE) sent++;
            end
        end
        wait_quiet();

        $display("covered %0d commands across %0d slot-count settings and three idle profiles",
                 items_sent, settings_done);
        $display("checked %0d transmitted frames and %0d status beats",
                 sb.frames_checked, sb.status_checked);
        if (sb.fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- can_cyclic_event_tx_scheduler.f -----
+incdir+src
src/cces_pkg.sv
src/cces_fifo.sv
src/cces_front.sv
src/cces_back.sv
src/can_cyclic_event_tx_scheduler.sv
verif/tb.sv
